@@ src/mtl_pkg.sv @@
// shared types, constants and helper functions of the mnemonic token lexer
package mtl_pkg;

  // token length limit and fixed field widths
  localparam int unsigned MAX_TOKEN_CHARS = 10;
  localparam int unsigned VALUE_W         = 31;
  localparam int unsigned MNEM_LEN        = 3;
  localparam int unsigned SLOT_W          = 7;
  localparam int unsigned OPCODE_W        = 5;

  // hash constants
  localparam logic [63:0] HASH_K0  = 64'hca4b195ebe20bb27;
  localparam logic [63:0] HASH_K1  = 64'hc85fd24c21bf27d9;
  localparam logic [63:0] HASH_K2  = 64'hb8016a2e00bed809;
  localparam logic [63:0] HASH_K3  = 64'hc2a16d719235e88f;
  localparam logic [63:0] HASH_K01 = 64'(HASH_K0 + HASH_K1);
  localparam logic [6:0]  HASH_MOD = 7'd127;

  // result kinds
  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_OPCODE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_BAD_CHAR   = 2'd0,
    ERR_LONG_TOKEN = 2'd1,
    ERR_BAD_TOKEN  = 2'd2,
    ERR_NUM_LARGE  = 2'd3
  } err_e;

  // running summary of the pending token
  typedef struct packed {
    logic                all_digits;
    logic                too_big;
    logic [VALUE_W-1:0]  num;
    logic [7:0]          ch0;
    logic [7:0]          ch1;
    logic [7:0]          ch2;
    logic [63:0]         hash;
  } tok_t;

  // mnemonic lookup answer
  typedef struct packed {
    logic                hit;
    logic [OPCODE_W-1:0] opcode;
  } lookup_t;

  // one slot of the mnemonic rom
  typedef struct packed {
    logic                used;
    logic [OPCODE_W-1:0] opcode;
    logic [23:0]         name;
  } rom_slot_t;

  // character classes
  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0a);
  endfunction

  // mnemonic rom, indexed by hash slot
  function automatic rom_slot_t rom_read(logic [SLOT_W-1:0] slot);
    rom_slot_t r;
    r = '{used: 1'b1, opcode: '0, name: '0};
    case (slot)
      7'd0:    begin r.opcode = 5'd17; r.name = "GTE"; end
      7'd2:    begin r.opcode = 5'd2;  r.name = "PRI"; end
      7'd8:    begin r.opcode = 5'd14; r.name = "CMP"; end
      7'd10:   begin r.opcode = 5'd24; r.name = "BXO"; end
      7'd19:   begin r.opcode = 5'd16; r.name = "LES"; end
      7'd20:   begin r.opcode = 5'd6;  r.name = "JIF"; end
      7'd23:   begin r.opcode = 5'd12; r.name = "DIV"; end
      7'd31:   begin r.opcode = 5'd13; r.name = "MOD"; end
      7'd38:   begin r.opcode = 5'd11; r.name = "MUL"; end
      7'd39:   begin r.opcode = 5'd27; r.name = "RSH"; end
      7'd44:   begin r.opcode = 5'd26; r.name = "LSH"; end
      7'd46:   begin r.opcode = 5'd7;  r.name = "JNO"; end
      7'd47:   begin r.opcode = 5'd1;  r.name = "EXE"; end
      7'd49:   begin r.opcode = 5'd20; r.name = "ORR"; end
      7'd50:   begin r.opcode = 5'd25; r.name = "BNO"; end
      7'd57:   begin r.opcode = 5'd18; r.name = "LTE"; end
      7'd60:   begin r.opcode = 5'd15; r.name = "MOR"; end
      7'd65:   begin r.opcode = 5'd10; r.name = "SUB"; end
      7'd66:   begin r.opcode = 5'd5;  r.name = "JMP"; end
      7'd68:   begin r.opcode = 5'd19; r.name = "AND"; end
      7'd70:   begin r.opcode = 5'd28; r.name = "END"; end
      7'd92:   begin r.opcode = 5'd21; r.name = "NOT"; end
      7'd97:   begin r.opcode = 5'd4;  r.name = "PRS"; end
      7'd99:   begin r.opcode = 5'd3;  r.name = "PRC"; end
      7'd108:  begin r.opcode = 5'd9;  r.name = "ADD"; end
      7'd118:  begin r.opcode = 5'd22; r.name = "BAN"; end
      7'd122:  begin r.opcode = 5'd0;  r.name = "ALO"; end
      7'd124:  begin r.opcode = 5'd8;  r.name = "MOV"; end
      7'd125:  begin r.opcode = 5'd23; r.name = "BOR"; end
      default: begin r.used = 1'b0; end
    endcase
    return r;
  endfunction

endpackage

@@ src/mtl_tok_acc.sv @@
// token accumulator: length, digit value, first three bytes and partial hash
module mtl_tok_acc #(
  parameter int unsigned MAX_TOKEN_CHARS = mtl_pkg::MAX_TOKEN_CHARS,
  localparam int unsigned LenW = $clog2(MAX_TOKEN_CHARS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             append_i,
  input  logic             clear_i,
  input  logic [7:0]       char_i,
  output logic [LenW-1:0]  len_o,
  output mtl_pkg::tok_t    tok_o
);

  localparam int unsigned NumW = mtl_pkg::VALUE_W + 4;

  logic [LenW-1:0] len_q, len_d;
  mtl_pkg::tok_t   tok_q, tok_d;
  logic            first;
  logic            dig;
  logic [NumW-1:0] base, prod;

  assign first = (len_q == '0);
  assign dig   = mtl_pkg::is_digit(char_i);
  assign base  = first ? '0 : {4'd0, tok_q.num};
  // value times ten plus the new digit
  assign prod  = (base << 3) + (base << 1) + NumW'(char_i[3:0]);

  // next token summary
  always_comb begin
    tok_d = tok_q;
    if (append_i) begin
      tok_d.all_digits = dig && (first || tok_q.all_digits);
      tok_d.too_big    = (prod[NumW-1:mtl_pkg::VALUE_W] != '0) || (!first && tok_q.too_big);
      tok_d.num        = prod[mtl_pkg::VALUE_W-1:0];
      case (len_q)
        LenW'(0): begin
          tok_d.ch0  = char_i;
          tok_d.hash = mtl_pkg::HASH_K01 + ({56'd0, char_i} << 13);
        end
        LenW'(1): begin
          tok_d.ch1  = char_i;
          tok_d.hash = tok_q.hash ^ (({56'd0, char_i} << 23) + mtl_pkg::HASH_K2);
        end
        LenW'(2): begin
          tok_d.ch2  = char_i;
          tok_d.hash = tok_q.hash ^ (({56'd0, char_i} << 25) + mtl_pkg::HASH_K3);
        end
        default: begin
        end
      endcase
    end
  end

  // length counter
  always_comb begin
    len_d = len_q;
    if (clear_i) begin
      len_d = '0;
    end else if (append_i) begin
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // token payload, no reset needed
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign len_o = len_q;
  assign tok_o = tok_q;

endmodule

@@ src/mtl_lookup.sv @@
// mnemonic lookup: hash mod 127, rom read and name compare
module mtl_lookup (
  input  mtl_pkg::tok_t    tok_i,
  output mtl_pkg::lookup_t res_o
);

  logic [10:0]              sum;
  logic [7:0]               fold;
  logic [mtl_pkg::SLOT_W-1:0] slot;
  mtl_pkg::rom_slot_t       entry;

  // 2^7 is 1 mod 127, so add the 7-bit digits
  always_comb begin
    sum = 11'(tok_i.hash[63]);
    for (int i = 0; i < 9; i++) begin
      sum = sum + 11'(tok_i.hash[7*i +: 7]);
    end
  end

  // second fold and final correction
  assign fold = 8'(sum[6:0]) + 8'(sum[10:7]);
  assign slot = (fold >= 8'(mtl_pkg::HASH_MOD)) ? 7'(fold - 8'(mtl_pkg::HASH_MOD))
                                                : fold[6:0];

  assign entry = mtl_pkg::rom_read(slot);

  // hit needs a used slot and the exact name
  assign res_o.hit    = entry.used && (entry.name == {tok_i.ch0, tok_i.ch1, tok_i.ch2});
  assign res_o.opcode = entry.opcode;

endmodule

@@ src/mnemonic_token_lexer_top.sv @@
// top level of the mnemonic token lexer: input register, decode and result register
// an accepted byte is held in the input register, and its result is then written to the result register
// throughput: one byte per cycle, limited only by the result register handshake
// a token result comes out on the space or newline that ends it
// reset clears the token length, the halt flag and both valid flags at once
module mnemonic_token_lexer_top #(
  parameter int unsigned MAX_TOKEN_CHARS = mtl_pkg::MAX_TOKEN_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [30:0] value_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned LenW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam logic [LenW-1:0] MaxLen  = LenW'(MAX_TOKEN_CHARS);
  localparam logic [LenW-1:0] MnemLen = LenW'(mtl_pkg::MNEM_LEN);

  logic                     in_vld_q, in_vld_d;
  logic [7:0]               char_q;
  logic                     eof_q;
  logic                     halted_q, halted_d;
  logic                     out_vld_q, out_vld_d;
  mtl_pkg::kind_e           kind_q, kind_d;
  logic [30:0]              value_q, value_d;
  mtl_pkg::err_e            err_q, err_d;
  logic                     advance, in_ready, accept, consume;
  logic                     emit, append, clear;
  logic [LenW-1:0]          len;
  mtl_pkg::tok_t            tok;
  mtl_pkg::lookup_t         lkp;

  // pipeline moves when the result register is free or being taken
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_ready   = !in_vld_q || advance;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;
  assign consume    = in_vld_q && advance;

  mtl_tok_acc #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_tok_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .append_i(append),
    .clear_i (clear),
    .char_i  (char_q),
    .len_o   (len),
    .tok_o   (tok)
  );

  mtl_lookup u_lookup (
    .tok_i(tok),
    .res_o(lkp)
  );

  // byte decode and result selection
  always_comb begin
    emit     = 1'b0;
    append   = 1'b0;
    clear    = 1'b0;
    halted_d = halted_q;
    kind_d   = mtl_pkg::KIND_ERROR;
    value_d  = '0;
    err_d    = mtl_pkg::ERR_BAD_CHAR;
    if (consume) begin
      if (!halted_q) begin
        if (mtl_pkg::is_alnum(char_q)) begin
          if (len >= MaxLen) begin
            emit     = 1'b1;
            halted_d = 1'b1;
            err_d    = mtl_pkg::ERR_LONG_TOKEN;
          end else begin
            append = 1'b1;
          end
        end else if (mtl_pkg::is_delim(char_q)) begin
          if (len != '0) begin
            emit  = 1'b1;
            clear = 1'b1;
            if (tok.all_digits) begin
              if (tok.too_big) begin
                halted_d = 1'b1;
                err_d    = mtl_pkg::ERR_NUM_LARGE;
              end else begin
                kind_d  = mtl_pkg::KIND_NUMBER;
                value_d = tok.num;
              end
            end else if ((len == MnemLen) && lkp.hit) begin
              kind_d  = mtl_pkg::KIND_OPCODE;
              value_d = 31'(lkp.opcode);
            end else begin
              halted_d = 1'b1;
              err_d    = mtl_pkg::ERR_BAD_TOKEN;
            end
          end
        end else begin
          emit     = 1'b1;
          halted_d = 1'b1;
          err_d    = mtl_pkg::ERR_BAD_CHAR;
        end
      end
      // end of file wipes the token and the halt
      if (eof_q) begin
        clear    = 1'b1;
        append   = 1'b0;
        halted_d = 1'b0;
      end
    end
    // error code reads zero outside errors
    if (kind_d != mtl_pkg::KIND_ERROR) begin
      err_d = mtl_pkg::ERR_BAD_CHAR;
    end
  end

  // valid flags of both stages
  assign in_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? (consume && emit) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      halted_q  <= halted_d;
    end
  end

  // input request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign error_code_o = err_q;

endmodule

@@ src/mtl_checker.sv @@
// port-level checker for the mnemonic token lexer and its bind
module mtl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_byte_i,
  input logic        end_of_file_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [30:0] value_o,
  input logic [1:0]  error_code_o
);

  // a new result needs a request that was accepted earlier and passed through the input register
  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding request");

  // error results carry a zero value
  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mtl_pkg::KIND_ERROR)) |-> (value_o == '0))
    else $error("error result with nonzero value");

  // non-error results carry a zero error code and a legal kind
  a_ok_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != mtl_pkg::KIND_ERROR)) |->
      ((error_code_o == mtl_pkg::ERR_BAD_CHAR) &&
       ((kind_o == mtl_pkg::KIND_NUMBER) || (kind_o == mtl_pkg::KIND_OPCODE))))
    else $error("bad kind or error code on result");

  // opcodes stay within the rom range
  a_opcode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == mtl_pkg::KIND_OPCODE)) |-> (value_o <= 31'd28))
    else $error("opcode out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(kind_o) && $stable(value_o) && $stable(error_code_o)))
    else $error("stalled result changed");

endmodule

bind mnemonic_token_lexer_top mtl_checker u_mtl_checker (.*);

@@ tb/sv/tb_mnemonic_token_lexer_top.sv @@
// testbench of the mnemonic token lexer: byte feed, result checker and token predictor
`timescale 1ns / 100ps

module tb_mnemonic_token_lexer_top;

  localparam int TOK_MAX      = 10;
  localparam int MNEM_COUNT   = 29;
  localparam int WATCHDOG_MAX = 1000;
  localparam int HOLD_CYCLES  = 160;
  localparam int HOLD_AT      = 40;
  localparam int TAIL_CYCLES  = 8;
  localparam int FEED_TARGET  = 1120;

  // hash mixing constants
  localparam logic [63:0] MIX_C0 = 64'hca4b195ebe20bb27;
  localparam logic [63:0] MIX_C1 = 64'hc85fd24c21bf27d9;
  localparam logic [63:0] MIX_C2 = 64'hb8016a2e00bed809;
  localparam logic [63:0] MIX_C3 = 64'hc2a16d719235e88f;

  // mnemonic table, one entry {slot, opcode, name} per mnemonic, first entry in the top bits
  localparam logic [MNEM_COUNT*40-1:0] MNEM_TABLE = {
    8'd0,   8'd17, "GTE", 8'd2,   8'd2,  "PRI", 8'd8,   8'd14, "CMP", 8'd10,  8'd24, "BXO",
    8'd19,  8'd16, "LES", 8'd20,  8'd6,  "JIF", 8'd23,  8'd12, "DIV", 8'd31,  8'd13, "MOD",
    8'd38,  8'd11, "MUL", 8'd39,  8'd27, "RSH", 8'd44,  8'd26, "LSH", 8'd46,  8'd7,  "JNO",
    8'd47,  8'd1,  "EXE", 8'd49,  8'd20, "ORR", 8'd50,  8'd25, "BNO", 8'd57,  8'd18, "LTE",
    8'd60,  8'd15, "MOR", 8'd65,  8'd10, "SUB", 8'd66,  8'd5,  "JMP", 8'd68,  8'd19, "AND",
    8'd70,  8'd28, "END", 8'd92,  8'd21, "NOT", 8'd97,  8'd4,  "PRS", 8'd99,  8'd3,  "PRC",
    8'd108, 8'd9,  "ADD", 8'd118, 8'd22, "BAN", 8'd122, 8'd0,  "ALO", 8'd124, 8'd8,  "MOV",
    8'd125, 8'd23, "BOR"
  };

  typedef struct packed {
    mtl_pkg::kind_e kind;
    logic [30:0]    value;
    mtl_pkg::err_e  code;
  } lex_result_t;

  typedef struct {
    logic [7:0] ch;
    logic       eof;
    int         gap;
    bit         drain;
  } src_byte_t;

  // dut signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte   = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid_o;
  logic        out_stall   = 1'b0;
  logic [1:0]  kind_o;
  logic [30:0] value_o;
  logic [1:0]  error_code_o;

  // stimulus and expectation stores
  src_byte_t   byte_feed_q[$];
  lex_result_t token_results_q[$];

  // predictor state
  logic [7:0]  tok_buf [TOK_MAX];
  int          tok_len    = 0;
  bit          lex_halted = 1'b0;

  // driver state
  src_byte_t   cur_byte;
  bit          staged    = 1'b0;
  int          gap_left  = 0;
  bit          fire;
  bit          offer;
  bit          sender_idle = 1'b0;

  // monitor state
  lex_result_t want;
  int          recv_wait = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // counters
  int          n_fed      = 0;
  int          n_accepted = 0;
  int          n_results  = 0;
  int          n_mismatch = 0;
  int          idle_cyc   = 0;
  int          kind_seen [3];
  int          err_seen  [4];

  mnemonic_token_lexer_top #(
    .MAX_TOKEN_CHARS(TOK_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .char_byte_i  (char_byte),
    .end_of_file_i(end_of_file),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .error_code_o (error_code_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [39:0] mnem_entry(int i);
    return MNEM_TABLE[(MNEM_COUNT-1-i)*40 +: 40];
  endfunction

  function automatic bit is_num_char(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_num_char(c) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'(8'h30 + r);
    else if (r < 36) return 8'(8'h41 + r - 10);
    return 8'(8'h61 + r - 36);
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_word_char(c) || c == 8'h20 || c == 8'h0a) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic emit_result(input mtl_pkg::kind_e k, input logic [30:0] v,
                             input mtl_pkg::err_e e);
    lex_result_t r;
    r.kind  = k;
    r.value = v;
    r.code  = e;
    token_results_q.push_back(r);
  endtask

  // token predictor: one accepted request in, zero or one expected result out
  task automatic predict_token_result(input logic [7:0] c, input logic eof);
    logic [63:0] num;
    logic [63:0] h;
    logic [39:0] ent;
    bit          all_num;
    bit          hit;
    int          slot;
    int          i;
    if (!lex_halted) begin
      if (is_word_char(c)) begin
        if (tok_len >= TOK_MAX) begin
          lex_halted = 1'b1;
          emit_result(mtl_pkg::KIND_ERROR, '0, mtl_pkg::ERR_LONG_TOKEN);
        end else begin
          tok_buf[tok_len] = c;
          tok_len++;
        end
      end else if (c == 8'h20 || c == 8'h0a) begin
        if (tok_len != 0) begin
          // all-digit tokens become numbers
          num     = '0;
          all_num = 1'b1;
          for (i = 0; i < tok_len; i++) begin
            if (all_num) begin
              if (is_num_char(tok_buf[i])) num = num * 10 + 64'(tok_buf[i] - 8'h30);
              else all_num = 1'b0;
            end
          end
          if (all_num) begin
            if (num > 64'd2147483647) begin
              lex_halted = 1'b1;
              emit_result(mtl_pkg::KIND_ERROR, '0, mtl_pkg::ERR_NUM_LARGE);
            end else begin
              // code field is zero outside errors
              emit_result(mtl_pkg::KIND_NUMBER, num[30:0], mtl_pkg::ERR_BAD_CHAR);
            end
          end else begin
            // three-letter tokens are hashed and matched against the table
            hit = 1'b0;
            if (tok_len == 3) begin
              h = (MIX_C0 + ((64'(tok_buf[0]) << 13) + MIX_C1))
                ^ ((64'(tok_buf[1]) << 23) + MIX_C2)
                ^ ((64'(tok_buf[2]) << 25) + MIX_C3);
              slot = int'(h % 64'd127);
              for (i = 0; i < MNEM_COUNT; i++) begin
                ent = mnem_entry(i);
                if (int'(ent[39:32]) == slot && ent[23:0] == {tok_buf[0], tok_buf[1], tok_buf[2]})
                begin
                  hit = 1'b1;
                  emit_result(mtl_pkg::KIND_OPCODE, 31'(ent[31:24]), mtl_pkg::ERR_BAD_CHAR);
                end
              end
            end
            if (!hit) begin
              lex_halted = 1'b1;
              emit_result(mtl_pkg::KIND_ERROR, '0, mtl_pkg::ERR_BAD_TOKEN);
            end
          end
          tok_len = 0;
        end
      end else begin
        lex_halted = 1'b1;
        emit_result(mtl_pkg::KIND_ERROR, '0, mtl_pkg::ERR_BAD_CHAR);
      end
    end
    if (eof) begin
      tok_len    = 0;
      lex_halted = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [7:0] c, input logic eof, input bit drain);
    src_byte_t b;
    b.ch    = c;
    b.eof   = eof;
    b.drain = drain;
    b.gap   = 0;
    if (sender_idle && $urandom_range(0, 2) == 0) b.gap = $urandom_range(0, 16);
    byte_feed_q.push_back(b);
    n_fed++;
  endtask

  task automatic push_text(input string s, input bit eof_last, input bit drain);
    int k;
    for (k = 0; k < s.len(); k++)
      push_byte(s[k], eof_last && (k == s.len() - 1), drain && (k == 0));
  endtask

  // driver: offers one request at a time, holds it until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      char_byte   <= 8'h00;
      end_of_file <= 1'b0;
    end else begin
      fire = in_valid && !in_stall_o;
      if (fire) begin
        predict_token_result(cur_byte.ch, cur_byte.eof);
        n_accepted++;
      end
      offer = in_valid && !fire;
      if (!offer) begin
        if (!staged && byte_feed_q.size() > 0) begin
          cur_byte = byte_feed_q.pop_front();
          staged   = 1'b1;
          gap_left = cur_byte.gap;
        end
        if (staged && gap_left > 0) begin
          gap_left--;
        end else if (staged && (!cur_byte.drain || token_results_q.size() == 0)) begin
          staged = 1'b0;
          offer  = 1'b1;
        end
      end
      in_valid <= offer;
      if (offer) begin
        char_byte   <= cur_byte.ch;
        end_of_file <= cur_byte.eof;
      end
    end
  end

  // monitor: checks each accepted result and drives the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_results++;
        if (token_results_q.size() == 0) begin
          report_mismatch($sformatf("result kind %0d value %0d with nothing expected",
                                    kind_o, value_o));
        end else begin
          want = token_results_q.pop_front();
          kind_seen[want.kind]++;
          if (want.kind == mtl_pkg::KIND_ERROR) err_seen[want.code]++;
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
          if (value_o !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", value_o, want.value));
          if (error_code_o !== want.code)
            report_mismatch($sformatf("error code %0d, expected %0d", error_code_o, want.code));
        end
        recv_wait = 0;
        if (((n_results / 40) % 3) != 0 && $urandom_range(0, 2) == 0)
          recv_wait = $urandom_range(0, 16);
      end
      // one long hold-off so the input side backs up
      if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WATCHDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  sent[$];
    logic [39:0] ent;
    string       s;
    int          ntok;
    int          t;
    int          k;
    int          len;
    int          pick;
    int          pos;

    // directed: bad first byte, halt, opcode extremes, number extremes, delimiters, eof cases
    sender_idle = 1'b0;
    push_byte(8'hff, 1'b0, 1'b0);
    push_byte("A", 1'b1, 1'b0);
    push_text("ALO ", 1'b0, 1'b0);
    push_text("END\n", 1'b0, 1'b0);
    sender_idle = 1'b1;
    push_text("2147483647 ", 1'b0, 1'b0);
    push_text("0 ", 1'b0, 1'b0);
    push_text(" ", 1'b0, 1'b0);
    push_text("x", 1'b1, 1'b0);

    // random: sentences of tokens ended by an eof byte
    while (n_fed < FEED_TARGET) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sent.delete();
      ntok = $urandom_range(1, 6);
      for (t = 0; t < ntok; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // known mnemonic
          ent = mnem_entry($urandom_range(0, MNEM_COUNT - 1));
          sent.push_back(ent[23:16]);
          sent.push_back(ent[15:8]);
          sent.push_back(ent[7:0]);
        end else if (pick < 60) begin
          // number, small, wide, near the limit or with leading zeros
          case ($urandom_range(0, 3))
            0: s = $sformatf("%0d", $urandom_range(0, 999));
            1: begin
              s   = "";
              len = $urandom_range(4, 10);
              for (k = 0; k < len; k++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            2: s = $sformatf("%0d", 64'd2147483646 + 64'($urandom_range(0, 2)));
            default: s = {"000", $sformatf("%0d", $urandom_range(0, 9999999))};
          endcase
          for (k = 0; k < s.len(); k++) sent.push_back(s[k]);
        end else if (pick < 75) begin
          // unknown or malformed mnemonic
          case ($urandom_range(0, 3))
            0: for (k = 0; k < 3; k++) sent.push_back(8'("A" + $urandom_range(0, 25)));
            1: begin
              ent = mnem_entry($urandom_range(0, MNEM_COUNT - 1));
              pos = $urandom_range(0, 2);
              ent[pos*8 +: 8] = ent[pos*8 +: 8] | 8'h20;
              sent.push_back(ent[23:16]);
              sent.push_back(ent[15:8]);
              sent.push_back(ent[7:0]);
            end
            2: begin
              len = $urandom_range(1, TOK_MAX);
              for (k = 0; k < len; k++) sent.push_back(rand_word_char());
            end
            default: begin
              ent = mnem_entry($urandom_range(0, MNEM_COUNT - 1));
              sent.push_back(ent[23:16]);
              sent.push_back(ent[15:8]);
              if ($urandom_range(0, 1)) begin
                sent.push_back(ent[7:0]);
                sent.push_back(rand_word_char());
              end
            end
          endcase
        end else if (pick < 82) begin
          // token past the length limit
          len = $urandom_range(TOK_MAX + 1, TOK_MAX + 3);
          for (k = 0; k < len; k++)
            sent.push_back($urandom_range(0, 1) ? rand_word_char() : 8'("0" + $urandom_range(0, 9)));
        end else if (pick < 88) begin
          sent.push_back(rand_bad_char());
        end else begin
          sent.push_back(8'($urandom_range(0, 255)));
        end
        // delimiters, sometimes a run of them
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 1;
        for (k = 0; k < len; k++) sent.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0a);
      end
      // ending: on a delimiter, on an open token, or on a random byte
      pick = $urandom_range(0, 99);
      if (pick >= 70 && pick < 85) begin
        while (sent.size() > 1 && (sent[$] == 8'h20 || sent[$] == 8'h0a)) void'(sent.pop_back());
      end else if (pick >= 85) begin
        sent.push_back(8'($urandom_range(0, 255)));
      end
      pick = ($urandom_range(0, 11) == 0);
      for (k = 0; k < sent.size(); k++)
        push_byte(sent[k], k == sent.size() - 1, (k == 0) && pick);
    end

    // reset, then wait for every request and result
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted < n_fed || token_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (token_results_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", token_results_q.size()));

    $display("run covered %0d bytes and %0d results: %0d numbers, %0d opcodes, %0d errors",
             n_accepted, n_results, kind_seen[mtl_pkg::KIND_NUMBER],
             kind_seen[mtl_pkg::KIND_OPCODE], kind_seen[mtl_pkg::KIND_ERROR]);
    $display("errors by cause: bad char %0d, long token %0d, bad token %0d, large number %0d",
             err_seen[mtl_pkg::ERR_BAD_CHAR], err_seen[mtl_pkg::ERR_LONG_TOKEN],
             err_seen[mtl_pkg::ERR_BAD_TOKEN], err_seen[mtl_pkg::ERR_NUM_LARGE]);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
